// File: design/http_request_framer_defines.svh
// ----------------------------------------------------------------------------
// HTTP request framer assertion macros
// Shared property forms for the framer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_FRAMER_DEFINES_SVH
`define HTTP_REQUEST_FRAMER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HRF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define HRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/hrf_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request framer package
// Payload types, byte classes, state encodings and framing constants.
// ----------------------------------------------------------------------------
package hrf_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int FIELD_LEN     = 15;
    localparam int FPOS_BITS     = $clog2(FIELD_LEN);
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QFILL_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] MAX_LEN_RESET = 16'd1000;
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [7:0] FIELD_NAME [FIELD_LEN] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A
    };

    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam logic [1:0] ST_HEADER = 2'd0;
    localparam logic [1:0] ST_BODY   = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;
    localparam logic [1:0] ST_OVFL   = 2'd3;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_BODY   = 4'b0010,
        PH_DONE   = 4'b0100,
        PH_OVFL   = 4'b1000
    } t_phase;

    typedef enum logic [3:0] {
        NS_NONE  = 4'b0001,
        NS_BLANK = 4'b0010,
        NS_DIGIT = 4'b0100,
        NS_END   = 4'b1000
    } t_num_stage;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] byte_count;
        logic [31:0] expected_len;
    } t_out_item;

    typedef struct packed {
        logic                 clear;
        logic                 is_cr;
        logic                 is_lf;
        logic                 is_c;
        logic                 is_blank;
        logic                 is_digit;
        logic [3:0]           digit;
        logic [FIELD_LEN-1:0] field_hit;
    } t_byte_class;

endpackage

// File: design/hrf_front.sv
// ----------------------------------------------------------------------------
// HTTP request framer front end
// Accepts input beats and classifies each byte for the back end.
// ----------------------------------------------------------------------------
module hrf_front
    import hrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    input  logic        i_q_ready,
    output logic        o_q_push,
    output t_byte_class o_q_item
);

    logic [7:0] w_byte;
    logic [7:0] w_digit_off;

    assign w_byte      = i_in_item.data_byte;
    assign w_digit_off = w_byte - CH_ZERO;
    assign o_in_ready  = i_q_ready;
    assign o_q_push    = i_in_valid && i_q_ready;

    always_comb begin
        o_q_item          = '0;
        o_q_item.clear    = (i_in_item.req_type == REQ_CLEAR);
        o_q_item.is_cr    = (w_byte == CH_CR);
        o_q_item.is_lf    = (w_byte == CH_LF);
        o_q_item.is_c     = (w_byte == FIELD_NAME[0]);
        o_q_item.is_blank = (w_byte == CH_SPACE) || (w_byte == CH_TAB);
        o_q_item.is_digit = (w_byte >= CH_ZERO) && (w_byte <= CH_NINE);
        o_q_item.digit    = w_digit_off[3:0];
        for (int k = 0; k < FIELD_LEN; k++) begin
            o_q_item.field_hit[k] = (w_byte == FIELD_NAME[k]);
        end
    end

    `include "http_request_framer_defines.svh"

    `HRF_ASSERT_NOW(a_push_needs_room, o_q_push, i_q_ready, "push without queue room")
    `HRF_ASSERT_NOW(a_digit_range, o_q_push && o_q_item.is_digit, o_q_item.digit <= 4'd9, "bad digit")
    `HRF_ASSERT_NOW(a_cr_not_lf, o_q_push, !(o_q_item.is_cr && o_q_item.is_lf), "cr and lf both set")

endmodule

// File: design/hrf_queue.sv
// ----------------------------------------------------------------------------
// HTTP request framer queue
// Short FIFO of classified beats between front and back end.
// ----------------------------------------------------------------------------
module hrf_queue
    import hrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_byte_class i_item,
    output logic        o_ready,
    output logic        o_valid,
    input  logic        i_pop,
    output t_byte_class o_item
);

    t_byte_class           r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wr_ptr;
    logic [QPTR_BITS-1:0]  r_rd_ptr;
    logic [QFILL_BITS-1:0] r_fill;
    logic [QPTR_BITS-1:0]  n_wr_ptr;
    logic [QPTR_BITS-1:0]  n_rd_ptr;
    logic [QFILL_BITS-1:0] n_fill;

    assign o_ready = (r_fill != QFILL_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_fill = r_fill + 1'b1;
            2'b01:   n_fill = r_fill - 1'b1;
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `include "http_request_framer_defines.svh"

    `HRF_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= QFILL_BITS'(QUEUE_DEPTH), "queue overfilled")
    `HRF_ASSERT_NOW(a_pop_nonempty, i_pop, r_fill != '0, "pop from empty queue")
    `HRF_ASSERT_NEXT(a_push_counts, i_push && !i_pop, r_fill == $past(r_fill) + 1'b1, "fill not advanced")

endmodule

// File: design/hrf_back.sv
// ----------------------------------------------------------------------------
// HTTP request framer back end
// Runs the header and length matchers, counts bytes, registers results.
// ----------------------------------------------------------------------------
module hrf_back
    import hrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_q_valid,
    input  t_byte_class i_q_item,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    logic [15:0]           r_max_len;
    t_phase                r_phase,     n_phase;
    t_num_stage            r_num_stage, n_num_stage;
    logic [1:0]            r_end_pos,   n_end_pos;
    logic [FPOS_BITS-1:0]  r_field_pos, n_field_pos;
    logic [31:0]           r_len,       n_len;
    logic [COUNT_BITS-1:0] r_count,     n_count;
    logic [31:0]           r_total,     n_total;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic [FPOS_BITS-1:0]  w_fpos;
    logic [35:0]           w_len_x10;
    logic [32:0]           w_sum;
    logic [31:0]           w_sum_sat;
    logic                  w_end_hit;
    logic [1:0]            w_status;

    assign o_q_pop     = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_fpos    = (r_field_pos < FPOS_BITS'(FIELD_LEN)) ? r_field_pos : '0;
    assign w_len_x10 = ({4'b0, r_len} << 3) + ({4'b0, r_len} << 1) + 36'(i_q_item.digit);
    assign w_end_hit = r_end_pos[0] ? i_q_item.is_lf : i_q_item.is_cr;

    always_comb begin
        n_phase     = r_phase;
        n_num_stage = r_num_stage;
        n_end_pos   = r_end_pos;
        n_field_pos = r_field_pos;
        n_len       = r_len;
        n_count     = r_count;
        n_total     = r_total;
        w_sum       = '0;
        w_sum_sat   = '0;
        if (o_q_pop) begin
            if (i_q_item.clear) begin
                n_phase     = PH_HEADER;
                n_num_stage = NS_NONE;
                n_end_pos   = '0;
                n_field_pos = '0;
                n_len       = '0;
                n_count     = '0;
                n_total     = '0;
            end else if (r_phase == PH_HEADER || r_phase == PH_BODY) begin
                if (32'(r_count) >= 32'(r_max_len) || r_count == COUNT_TOP) begin
                    n_phase = PH_OVFL;
                end else begin
                    n_count = r_count + 1'b1;
                    if (r_phase == PH_HEADER) begin
                        case (r_num_stage)
                            NS_NONE: begin
                                if (i_q_item.field_hit[w_fpos]) begin
                                    if (w_fpos == FPOS_BITS'(FIELD_LEN - 1)) begin
                                        n_num_stage = NS_BLANK;
                                        n_field_pos = '0;
                                    end else begin
                                        n_field_pos = w_fpos + 1'b1;
                                    end
                                end else begin
                                    n_field_pos = i_q_item.is_c ? FPOS_BITS'(1) : '0;
                                end
                            end
                            NS_BLANK, NS_DIGIT: begin
                                if (i_q_item.is_digit) begin
                                    n_len = (w_len_x10[35:32] != '0) ? '1 : w_len_x10[31:0];
                                    n_num_stage = NS_DIGIT;
                                end else if (!(r_num_stage == NS_BLANK && i_q_item.is_blank)) begin
                                    n_num_stage = NS_END;
                                end
                            end
                            default: ;
                        endcase
                        // the terminating LF never touches the length value, and the sum reads the registered stage
                        w_sum     = 33'(n_count) + ((r_num_stage != NS_NONE) ? 33'(r_len) : '0);
                        w_sum_sat = w_sum[32] ? '1 : w_sum[31:0];
                        if (w_end_hit) begin
                            if (r_end_pos == 2'd3) begin
                                n_end_pos = '0;
                                n_total   = w_sum_sat;
                                n_phase   = (32'(n_count) >= w_sum_sat) ? PH_DONE : PH_BODY;
                            end else begin
                                n_end_pos = r_end_pos + 1'b1;
                            end
                        end else begin
                            n_end_pos = i_q_item.is_cr ? 2'd1 : 2'd0;
                        end
                    end else if (32'(n_count) >= r_total) begin
                        n_phase = PH_DONE;
                    end
                end
            end
        end
    end

    always_comb begin
        case (n_phase)
            PH_HEADER: w_status = ST_HEADER;
            PH_BODY:   w_status = ST_BODY;
            PH_DONE:   w_status = ST_DONE;
            PH_OVFL:   w_status = ST_OVFL;
            default:   w_status = ST_HEADER;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= MAX_LEN_RESET;
            r_phase     <= PH_HEADER;
            r_num_stage <= NS_NONE;
            r_end_pos   <= '0;
            r_field_pos <= '0;
            r_len       <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            r_phase     <= n_phase;
            r_num_stage <= n_num_stage;
            r_end_pos   <= n_end_pos;
            r_field_pos <= n_field_pos;
            r_len       <= n_len;
            r_count     <= n_count;
            r_total     <= n_total;
            if (o_q_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out_item.status       <= w_status;
            r_out_item.byte_count   <= 16'(n_count);
            r_out_item.expected_len <= n_total;
        end
    end

    `include "http_request_framer_defines.svh"

    `HRF_ASSERT_NOW(a_hdr_no_total, r_phase == PH_HEADER, r_total == '0, "total set in header")
    `HRF_ASSERT_NOW(a_done_reached, r_phase == PH_DONE, 32'(r_count) >= r_total, "done before total")
    `HRF_ASSERT_NEXT(a_clear_resets, o_q_pop && i_q_item.clear, r_count == '0 && r_phase == PH_HEADER, "clear ignored")
    `HRF_ASSERT_NEXT(a_done_holds, o_q_pop && !i_q_item.clear && r_phase == PH_DONE, $stable(r_count), "count moved after done")

endmodule

// File: design/http_request_framer.sv
// ----------------------------------------------------------------------------
// HTTP request framer
// Frames request bytes by header end and Content-Length, one result per beat.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                   | payload
//  in       | input     | i_in_valid / o_in_ready     | i_in_item  (req_type, data_byte)
//  out      | output    | o_out_valid / i_out_ready   | o_out_item (status, byte_count,
//           |           |                             |             expected_len)
//  cfg      | input     | i_cfg_we                    | i_cfg_wdata (max_request_len)
//
//  One beat per cycle sustained while the output is not stalled; a result passes
//  through a queue entry and then the back end's output register after its beat
//  is accepted, and is taken at the next edge with ready high.
//  The four-entry queue lets the front accept up to four beats while the output
//  is stalled; then o_in_ready drops until the back end pops again.
//  Synchronous reset sets max_request_len to 1000 and clears the framing state.
// ----------------------------------------------------------------------------
module http_request_framer
    import hrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    logic        w_q_ready;
    logic        w_q_push;
    t_byte_class w_q_in;
    logic        w_q_valid;
    logic        w_q_pop;
    t_byte_class w_q_out;

    hrf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_ready  (w_q_ready),
        .o_q_push   (w_q_push),
        .o_q_item   (w_q_in)
    );

    hrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_q_in),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_item  (w_q_out)
    );

    hrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_out),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
